// File: hw/rtl/bou_pkg.sv
// bou_pkg: payload structs, multiply/divide unit request and response,
// fixed-point constants and the CORDIC arctangent table for the odometry block.
// No dependencies.
package bou_pkg;

	typedef struct packed {
		logic signed [31:0] tick_count;
		logic signed [15:0] steer_command;
	} bou_in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic        [15:0] heading;
		logic signed [63:0] total_distance;
	} bou_out_t;

	typedef struct packed {
		logic        start;
		logic        op_div;
		logic [63:0] a;
		logic [63:0] b;
	} bou_md_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
		logic [63:0] rem;
	} bou_md_rsp_t;

	localparam logic [2:0] CFG_START_X       = 3'd0;
	localparam logic [2:0] CFG_START_Y       = 3'd1;
	localparam logic [2:0] CFG_START_HEADING = 3'd2;
	localparam logic [2:0] CFG_WHEEL_BASE    = 3'd3;
	localparam logic [2:0] CFG_DIST_PER_TICK = 3'd4;
	localparam logic [2:0] CFG_MAX_STEER     = 3'd5;

	localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
	localparam logic        [31:0] TURN_PER_RAD = 32'd683565276;
	localparam logic        [46:0] R_MAX        = 47'h7FFF_FFFF_FFFF;
	localparam logic        [63:0] MUL_A_MAX    = 64'h1000_0000_0000_0000;

	function automatic logic [31:0] atan_at(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/bou_muldiv.sv
// bou_muldiv: shared bit-serial unit, 64x32 shift-add multiply (low 64 bits)
// and 64/64 restoring divide with remainder, one bit per cycle.
// Depends on bou_pkg.
module bou_muldiv (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bou_pkg::bou_md_req_t req,
	output bou_pkg::bou_md_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic        div_q;
	logic [5:0]  cnt_q;
	logic [63:0] x_q;
	logic [63:0] y_q;
	logic [63:0] acc_q;

	logic [64:0] shin;
	logic [64:0] addend;
	logic [65:0] sumw;
	logic        ge;

	assign shin   = div_q ? {acc_q, y_q[63]} : {1'b0, acc_q};
	assign addend = div_q ? ~{1'b0, x_q} : (y_q[0] ? {1'b0, x_q} : 65'd0);
	assign sumw   = {1'b0, shin} + {1'b0, addend} + {65'd0, div_q};
	assign ge     = sumw[65];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			div_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				div_q  <= req.op_div;
				cnt_q  <= req.op_div ? 6'd63 : 6'd31;
				acc_q  <= '0;
				if (req.op_div) begin
					x_q <= req.b;
					y_q <= req.a;
				end else begin
					x_q <= req.a;
					y_q <= req.b;
				end
			end else if (busy_q) begin
				if (div_q) begin
					acc_q <= ge ? sumw[63:0] : shin[63:0];
					y_q   <= {y_q[62:0], ge};
				end else begin
					acc_q <= sumw[63:0];
					x_q   <= {x_q[62:0], 1'b0};
					y_q   <= {1'b0, y_q[63:1]};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = div_q ? y_q : acc_q;
	assign rsp.rem  = acc_q;

endmodule

// File: hw/rtl/bicycle_odometry_update.sv
// bicycle_odometry_update: bicycle-model dead-reckoning pose tracker, top level.
// Depends on bou_pkg and bou_muldiv.
//
// One beat in gives one beat out; the block takes one beat at a time and is not
// ready until its result is in the output register. A beat with no tick change
// takes two multiplies, a straight move six multiplies and one CORDIC pass, and
// a turn nine multiplies, three divides and three CORDIC passes, all run on the
// shared one-bit-per-cycle multiply/divide unit and the iterative CORDIC (one
// rotation per cycle, at most 32). A result still waiting in the output register
// holds the block until it is taken. Configuration writes are taken at any time
// but are meant for when the block is idle; a start value write also loads the
// matching pose register.
module bicycle_odometry_update #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bou_pkg::bou_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output bou_pkg::bou_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	localparam int         CORD_N    = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
	localparam logic [4:0] CORD_LAST = 5'(CORD_N - 1);

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_WAIT   = 5'd1;
	localparam logic [4:0] ST_CORD   = 5'd2;
	localparam logic [4:0] ST_TOT    = 5'd3;
	localparam logic [4:0] ST_DIST   = 5'd4;
	localparam logic [4:0] ST_CA     = 5'd5;
	localparam logic [4:0] ST_C1     = 5'd6;
	localparam logic [4:0] ST_RRM    = 5'd7;
	localparam logic [4:0] ST_RRD    = 5'd8;
	localparam logic [4:0] ST_QD     = 5'd9;
	localparam logic [4:0] ST_FD     = 5'd10;
	localparam logic [4:0] ST_M1     = 5'd11;
	localparam logic [4:0] ST_M2     = 5'd12;
	localparam logic [4:0] ST_C2     = 5'd13;
	localparam logic [4:0] ST_MQ_HI  = 5'd14;
	localparam logic [4:0] ST_MQ_LO  = 5'd15;
	localparam logic [4:0] ST_MQ_END = 5'd16;
	localparam logic [4:0] ST_POSE   = 5'd17;
	localparam logic [4:0] ST_OUT    = 5'd18;

	function automatic logic [34:0] cord_fold(input logic [31:0] ang);
		logic signed [33:0] z;
		logic               neg;
		z   = 34'(signed'(ang));
		neg = 1'b0;
		if (z > 34'sd1073741824) begin
			z   = z - 34'sd2147483648;
			neg = 1'b1;
		end else if (z < -34'sd1073741824) begin
			z   = z + 34'sd2147483648;
			neg = 1'b1;
		end
		return {neg, z};
	endfunction

	function automatic logic [31:0] abs34(input logic signed [33:0] v);
		return v < 0 ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic [31:0] abs35(input logic signed [34:0] v);
		return v < 0 ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic [32:0] abs33(input logic signed [32:0] v);
		return v < 0 ? 33'(-v) : 33'(v);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	logic [4:0]          state_q;
	logic [4:0]          ret_q;
	logic [4:0]          cord_ret_q;
	bou_pkg::bou_md_req_t md_req_q;
	bou_pkg::bou_md_rsp_t md_rsp;

	logic [30:0]         wb_q;
	logic [30:0]         dpt_q;
	logic [13:0]         max_steer_q;
	logic signed [31:0]  pose_x_q;
	logic signed [31:0]  pose_y_q;
	logic [15:0]         pose_h_q;
	logic signed [31:0]  last_ticks_q;

	logic signed [32:0]  delta_q;
	logic signed [31:0]  alfa_q;
	logic                tneg_q;
	logic                dneg_q;
	logic                rneg_q;
	logic signed [63:0]  total_q;
	logic [63:0]         dd_q;
	logic signed [33:0]  ca_q;
	logic signed [33:0]  sa_q;
	logic signed [33:0]  c1_q;
	logic signed [33:0]  s1_q;
	logic [46:0]         rr_q;
	logic [63:0]         q_q;
	logic [15:0]         f_q;
	logic [63:0]         m1_q;
	logic [63:0]         mq_ua_q;
	logic [63:0]         mq_hi_q;
	logic [31:0]         bx_q;
	logic [31:0]         by_q;
	logic                nx_q;
	logic                ny_q;
	logic                mq_sel_q;
	logic signed [63:0]  dx_q;
	logic signed [63:0]  dy_q;

	logic signed [33:0]  cx_q;
	logic signed [33:0]  cy_q;
	logic signed [33:0]  cz_q;
	logic                cneg_q;
	logic [4:0]          ci_q;

	logic                out_valid_q;
	bou_pkg::bou_out_t   out_q;

	logic signed [32:0]  delta_c;
	logic signed [31:0]  alfa_c;
	logic [31:0]         h32;
	logic signed [33:0]  xs;
	logic signed [33:0]  ys;
	logic signed [33:0]  at;
	logic signed [33:0]  c_cos;
	logic signed [33:0]  c_sin;
	logic [46:0]         rr_c;
	logic [63:0]         mag_c;
	logic [63:0]         mag_s;
	logic [31:0]         a2_c;
	logic [31:0]         hd_c;
	logic signed [34:0]  dsx;
	logic signed [34:0]  dcy;
	logic [31:0]         mq_b;
	logic                mq_n;
	logic [63:0]         mq_r;
	logic [63:0]         mq_d;
	logic signed [63:0]  sum_x;
	logic signed [63:0]  sum_y;

	bou_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req_q),
		.rsp    (md_rsp)
	);

	assign delta_c = 33'(in_data.tick_count) - 33'(last_ticks_q);
	assign alfa_c  = (32'(in_data.steer_command) * 32'($signed({1'b0, max_steer_q}))) <<< 1;
	assign h32     = {pose_h_q, 16'h0000};
	assign xs      = cx_q >>> ci_q;
	assign ys      = cy_q >>> ci_q;
	assign at      = $signed({2'b00, bou_pkg::atan_at(ci_q)});
	assign c_cos   = cneg_q ? -cx_q : cx_q;
	assign c_sin   = cneg_q ? -cy_q : cy_q;
	assign rr_c    = (md_rsp.res == 64'd0) ? 47'd1 :
			(md_rsp.res > {17'd0, bou_pkg::R_MAX}) ? bou_pkg::R_MAX : md_rsp.res[46:0];
	assign mag_c   = m1_q + (md_rsp.res >> 16);
	assign mag_s   = (dneg_q != rneg_q) ? -mag_c : mag_c;
	assign a2_c    = h32 + mag_s[31:0];
	assign hd_c    = a2_c + 32'h0000_8000;
	assign dsx     = 35'(c_sin) - 35'(s1_q);
	assign dcy     = 35'(c1_q) - 35'(c_cos);
	assign mq_b    = mq_sel_q ? by_q : bx_q;
	assign mq_n    = mq_sel_q ? ny_q : nx_q;
	assign mq_r    = mq_hi_q + (md_rsp.res >> 30);
	assign mq_d    = mq_n ? -mq_r : mq_r;
	assign sum_x   = 64'(pose_x_q) + dx_q;
	assign sum_y   = 64'(pose_y_q) + dy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ret_q        <= ST_IDLE;
			cord_ret_q   <= ST_IDLE;
			md_req_q     <= '0;
			wb_q         <= 31'd65536;
			dpt_q        <= 31'd655;
			max_steer_q  <= 14'd4096;
			pose_x_q     <= '0;
			pose_y_q     <= '0;
			pose_h_q     <= '0;
			last_ticks_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			md_req_q.start <= 1'b0;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						delta_q      <= delta_c;
						alfa_q       <= alfa_c;
						tneg_q       <= in_data.tick_count < 0;
						dneg_q       <= delta_c < 0;
						last_ticks_q <= in_data.tick_count;
						md_req_q     <= '{1'b1, 1'b0,
								{31'd0, abs33(33'(in_data.tick_count))},
								{33'd0, dpt_q}};
						ret_q        <= ST_TOT;
						state_q      <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (md_rsp.done) state_q <= ret_q;
				end
				ST_CORD: begin
					if (cz_q >= 0) begin
						cx_q <= cx_q - ys;
						cy_q <= cy_q + xs;
						cz_q <= cz_q - at;
					end else begin
						cx_q <= cx_q + ys;
						cy_q <= cy_q - xs;
						cz_q <= cz_q + at;
					end
					ci_q <= ci_q + 5'd1;
					if (ci_q == CORD_LAST) state_q <= cord_ret_q;
				end
				ST_TOT: begin
					total_q  <= tneg_q ? -$signed(md_rsp.res) : $signed(md_rsp.res);
					md_req_q <= '{1'b1, 1'b0, {31'd0, abs33(delta_q)}, {33'd0, dpt_q}};
					ret_q    <= ST_DIST;
					state_q  <= ST_WAIT;
				end
				ST_DIST: begin
					dd_q <= md_rsp.res;
					if (delta_q == 33'sd0) begin
						state_q <= ST_OUT;
					end else begin
						{cneg_q, cz_q} <= cord_fold(alfa_q != 32'sd0 ? alfa_q : h32);
						cx_q           <= bou_pkg::CORDIC_GAIN;
						cy_q           <= '0;
						ci_q           <= '0;
						cord_ret_q     <= (alfa_q != 32'sd0) ? ST_CA : ST_C1;
						state_q        <= ST_CORD;
					end
				end
				ST_CA: begin
					ca_q           <= c_cos;
					sa_q           <= c_sin;
					{cneg_q, cz_q} <= cord_fold(h32);
					cx_q           <= bou_pkg::CORDIC_GAIN;
					cy_q           <= '0;
					ci_q           <= '0;
					cord_ret_q     <= ST_C1;
					state_q        <= ST_CORD;
				end
				ST_C1: begin
					c1_q <= c_cos;
					s1_q <= c_sin;
					if (alfa_q == 32'sd0 || sa_q == 34'sd0) begin
						mq_ua_q  <= (dd_q > bou_pkg::MUL_A_MAX) ? bou_pkg::MUL_A_MAX : dd_q;
						bx_q     <= abs34(c_cos);
						nx_q     <= dneg_q ^ (c_cos < 0);
						by_q     <= abs34(c_sin);
						ny_q     <= dneg_q ^ (c_sin < 0);
						mq_sel_q <= 1'b0;
						state_q  <= ST_MQ_HI;
					end else begin
						rneg_q   <= (ca_q < 0) != (sa_q < 0);
						md_req_q <= '{1'b1, 1'b0, {33'd0, wb_q}, {32'd0, abs34(ca_q)}};
						ret_q    <= ST_RRM;
						state_q  <= ST_WAIT;
					end
				end
				ST_RRM: begin
					md_req_q <= '{1'b1, 1'b1, md_rsp.res, {32'd0, abs34(sa_q)}};
					ret_q    <= ST_RRD;
					state_q  <= ST_WAIT;
				end
				ST_RRD: begin
					rr_q     <= rr_c;
					md_req_q <= '{1'b1, 1'b1, dd_q, {17'd0, rr_c}};
					ret_q    <= ST_QD;
					state_q  <= ST_WAIT;
				end
				ST_QD: begin
					q_q      <= md_rsp.res;
					md_req_q <= '{1'b1, 1'b1, {1'b0, md_rsp.rem[46:0], 16'd0}, {17'd0, rr_q}};
					ret_q    <= ST_FD;
					state_q  <= ST_WAIT;
				end
				ST_FD: begin
					f_q      <= md_rsp.res[15:0];
					md_req_q <= '{1'b1, 1'b0, q_q, {32'd0, bou_pkg::TURN_PER_RAD}};
					ret_q    <= ST_M1;
					state_q  <= ST_WAIT;
				end
				ST_M1: begin
					m1_q     <= md_rsp.res;
					md_req_q <= '{1'b1, 1'b0, {48'd0, f_q}, {32'd0, bou_pkg::TURN_PER_RAD}};
					ret_q    <= ST_M2;
					state_q  <= ST_WAIT;
				end
				ST_M2: begin
					pose_h_q       <= hd_c[31:16];
					{cneg_q, cz_q} <= cord_fold(a2_c);
					cx_q           <= bou_pkg::CORDIC_GAIN;
					cy_q           <= '0;
					ci_q           <= '0;
					cord_ret_q     <= ST_C2;
					state_q        <= ST_CORD;
				end
				ST_C2: begin
					mq_ua_q  <= {17'd0, rr_q};
					bx_q     <= abs35(dsx);
					nx_q     <= rneg_q ^ (dsx < 0);
					by_q     <= abs35(dcy);
					ny_q     <= rneg_q ^ (dcy < 0);
					mq_sel_q <= 1'b0;
					state_q  <= ST_MQ_HI;
				end
				ST_MQ_HI: begin
					md_req_q <= '{1'b1, 1'b0, mq_ua_q >> 30, {32'd0, mq_b}};
					ret_q    <= ST_MQ_LO;
					state_q  <= ST_WAIT;
				end
				ST_MQ_LO: begin
					mq_hi_q  <= md_rsp.res;
					md_req_q <= '{1'b1, 1'b0, {34'd0, mq_ua_q[29:0]}, {32'd0, mq_b}};
					ret_q    <= ST_MQ_END;
					state_q  <= ST_WAIT;
				end
				ST_MQ_END: begin
					if (!mq_sel_q) begin
						dx_q     <= $signed(mq_d);
						mq_sel_q <= 1'b1;
						state_q  <= ST_MQ_HI;
					end else begin
						dy_q    <= $signed(mq_d);
						state_q <= ST_POSE;
					end
				end
				ST_POSE: begin
					pose_x_q <= sat32(sum_x);
					pose_y_q <= sat32(sum_y);
					state_q  <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= '{pose_x_q, pose_y_q, pose_h_q, total_q};
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cfg_valid) begin
				case (cfg_index)
					bou_pkg::CFG_START_X:       pose_x_q    <= $signed(cfg_data);
					bou_pkg::CFG_START_Y:       pose_y_q    <= $signed(cfg_data);
					bou_pkg::CFG_START_HEADING: pose_h_q    <= cfg_data[15:0];
					bou_pkg::CFG_WHEEL_BASE:    wb_q        <= cfg_data[30:0];
					bou_pkg::CFG_DIST_PER_TICK: dpt_q       <= cfg_data[30:0];
					bou_pkg::CFG_MAX_STEER:     max_steer_q <= cfg_data[13:0];
					default: ;
				endcase
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for bicycle_odometry_update with its own pose predictor.
// Needs bou_pkg and the block's RTL only.
module tb_top;

	localparam int STEPS = 16;
	localparam logic [31:0] ARCTAN [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000};
	localparam logic [2:0] CFG_SPARE_6 = 3'd6;
	localparam logic [2:0] CFG_SPARE_7 = 3'd7;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	bou_pkg::bou_in_t in_data;
	bou_pkg::bou_out_t out_data;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	bicycle_odometry_update #(.CORDIC_STEPS(STEPS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic signed [31:0] pose_x = 0, pose_y = 0, prev_ticks = 0;
	logic [15:0] pose_hdg = 0;
	logic [30:0] wheel_base = 31'd65536, dist_per_tick = 31'd655;
	logic [13:0] max_steer = 14'd4096;

	bou_pkg::bou_in_t pending_beats[$];
	bou_pkg::bou_out_t expected_poses[$];
	int errors = 0;
	bit no_idle = 0;
	int n_sent = 0, n_taken = 0, hold_reqs = 0, holds_done = 0;
	int tx_gap = 0, rx_gap = 0, rx_hold = 0;
	logic signed [31:0] gen_ticks = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("bicycle_odometry_update test failed");
		$finish;
	end

	function automatic logic [63:0] mag(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [31:0] sat32(input longint v);
		if (v > 64'sd2147483647) return 32'h7FFFFFFF;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
		longint z, x, y, xs, ys;
		bit neg;
		z = longint'(signed'(ang));
		x = 64'sd652032874;
		y = 0;
		neg = 0;
		if (z > 64'sd1073741824) begin
			z -= 64'sd2147483648;
			neg = 1;
		end else if (z < -64'sd1073741824) begin
			z += 64'sd2147483648;
			neg = 1;
		end
		for (int i = 0; i < STEPS && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(ARCTAN[i]);
			end else begin
				x += ys; y -= xs; z += longint'(ARCTAN[i]);
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endtask

	function automatic longint mul_q30(input longint a, input longint b);
		logic [63:0] ua, ub, r;
		ua = mag(a);
		ub = mag(b);
		if (ua > 64'h1000_0000_0000_0000) ua = 64'h1000_0000_0000_0000;
		r = (ua >> 30) * ub + (((ua & 64'h3FFFFFFF) * ub) >> 30);
		return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
	endfunction

	task automatic advance_pose(input bou_pkg::bou_in_t beat);
		longint delta, travel, alfa, ca, sa, c1, s1, c2, s2, dx, dy, r;
		logic [63:0] rr, dd, q, m, f, turn;
		logic [31:0] h32, a2, rnd;
		bit rneg;
		bou_pkg::bou_out_t e;
		delta = longint'(beat.tick_count) - longint'(prev_ticks);
		travel = delta * longint'({1'b0, dist_per_tick});
		ca = 0;
		sa = 0;
		if (delta != 0) begin
			h32 = {pose_hdg, 16'h0};
			alfa = longint'(beat.steer_command) * longint'({1'b0, max_steer}) * 2;
			if (alfa != 0) rotate(alfa[31:0], ca, sa);
			rotate(h32, c1, s1);
			if (alfa == 0 || sa == 0) begin
				dx = mul_q30(travel, c1);
				dy = mul_q30(travel, s1);
			end else begin
				rr = (64'(wheel_base) * mag(ca)) / mag(sa);
				rneg = (ca < 0) != (sa < 0);
				if (rr < 1) rr = 1;
				if (rr > 64'h7FFF_FFFF_FFFF) rr = 64'h7FFF_FFFF_FFFF;
				dd = mag(travel);
				q = dd / rr;
				m = dd % rr;
				f = (m << 16) / rr;
				turn = q * 64'd683565276 + ((f * 64'd683565276) >> 16);
				if ((travel < 0) != rneg) turn = -turn;
				a2 = h32 + turn[31:0];
				rotate(a2, c2, s2);
				r = rneg ? -longint'(rr) : longint'(rr);
				dx = mul_q30(r, s2 - s1);
				dy = mul_q30(r, c1 - c2);
				rnd = a2 + 32'h8000;
				pose_hdg = rnd[31:16];
			end
			pose_x = sat32(longint'(pose_x) + dx);
			pose_y = sat32(longint'(pose_y) + dy);
		end
		prev_ticks = beat.tick_count;
		e.pos_x = pose_x;
		e.pos_y = pose_y;
		e.heading = pose_hdg;
		e.total_distance = longint'(beat.tick_count) * longint'({1'b0, dist_per_tick});
		expected_poses.push_back(e);
	endtask

	task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch on %s: got %h, expected %h", field, got, want);
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 4);
		if (r < 98) return $urandom_range(5, 25);
		return $urandom_range(50, 250);
	endfunction

	// input driver
	always @(negedge clk) begin
		if (arst_n && n_sent == n_taken) begin
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				in_data <= pending_beats.pop_front();
				in_valid <= 1'b1;
				n_sent++;
				tx_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result ready, with an occasional long hold-off
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (holds_done != hold_reqs) begin
			holds_done++;
			rx_hold = 3000;
			out_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			rx_gap = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			advance_pose(in_data);
			n_taken++;
		end
		if (out_valid && out_ready) begin
			if (expected_poses.size() == 0) begin
				report("unexpected beat", 64'd1, 64'd0);
			end else begin
				bou_pkg::bou_out_t e;
				e = expected_poses.pop_front();
				if (out_data.pos_x !== e.pos_x)
					report("pos_x", 64'(out_data.pos_x), 64'(e.pos_x));
				if (out_data.pos_y !== e.pos_y)
					report("pos_y", 64'(out_data.pos_y), 64'(e.pos_y));
				if (out_data.heading !== e.heading)
					report("heading", 64'(out_data.heading), 64'(e.heading));
				if (out_data.total_distance !== e.total_distance)
					report("total_distance", out_data.total_distance, e.total_distance);
			end
		end
	end

	task automatic wait_drained();
		while (pending_beats.size() > 0 || n_sent != n_taken || expected_poses.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			bou_pkg::CFG_START_X: pose_x = val;
			bou_pkg::CFG_START_Y: pose_y = val;
			bou_pkg::CFG_START_HEADING: pose_hdg = val[15:0];
			bou_pkg::CFG_WHEEL_BASE: wheel_base = val[30:0];
			bou_pkg::CFG_DIST_PER_TICK: dist_per_tick = val[30:0];
			bou_pkg::CFG_MAX_STEER: max_steer = val[13:0];
			default: ;
		endcase
	endtask

	task automatic push_beat(input logic signed [31:0] t, input logic signed [15:0] s);
		bou_pkg::bou_in_t b;
		b.tick_count = t;
		b.steer_command = s;
		pending_beats.push_back(b);
		gen_ticks = t;
	endtask

	task automatic push_random();
		int r;
		logic signed [31:0] t;
		logic signed [15:0] s;
		r = $urandom_range(0, 99);
		if (r < 8) t = gen_ticks;
		else if (r < 80) t = gen_ticks + $urandom_range(0, 200) - 100;
		else if (r < 90) t = gen_ticks + $urandom_range(0, 200000) - 100000;
		else t = $urandom;
		r = $urandom_range(0, 99);
		if (r < 25) s = 16'sd0;
		else if (r < 33) s = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
		else s = 16'($urandom);
		push_beat(t, s);
	endtask

	function automatic logic [31:0] pick_len(input int ph);
		case ($urandom_range(0, 3))
			0: return (ph % 2 != 0) ? 32'd1 : 32'h7FFFFFFF;
			1: return $urandom_range(1, 655360);
			2: return $urandom;
			default: return $urandom_range(1, 5000);
		endcase
	endfunction

	initial begin
		logic [31:0] v;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		cfg_valid = 0;
		cfg_index = bou_pkg::CFG_START_X;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed beats under the reset settings
		push_beat(0, 0);
		push_beat(100, 0);
		push_beat(200, 16'sh7FFF);
		push_beat(300, 16'sh8000);
		push_beat(300, 16'sd5);
		push_beat(400, 16'sh4000);
		push_beat(500, -16'sh4000);
		push_beat(450, 16'sd1);
		push_beat(32'h7FFFFFFF, 0);
		push_beat(32'h80000000, 16'sh7FFF);
		push_beat(32'h7FFFFFFF, 16'sh8000);
		push_beat(-32'sd1, -16'sd1);
		push_beat(0, 16'sh5555);
		push_beat(32'h55555555, 16'shAAAA);
		push_beat(32'hAAAAAAAA, 16'sh5555);
		push_beat(32'hAAAAAAAA, 0);
		wait_drained();

		for (int ph = 1; ph <= 9; ph++) begin
			no_idle = (ph % 4 == 3);
			write_reg(bou_pkg::CFG_START_X,
					(ph == 2) ? 32'h7FFFFFFF : (ph == 3) ? 32'h80000000 : $urandom);
			write_reg(bou_pkg::CFG_START_Y,
					(ph == 2) ? 32'h80000000 : (ph == 3) ? 32'h7FFFFFFF : $urandom);
			write_reg(bou_pkg::CFG_START_HEADING, (ph == 2) ? 32'h0000FFFF : $urandom);
			v = pick_len(ph);
			write_reg(bou_pkg::CFG_WHEEL_BASE, {$urandom_range(0, 1) != 0, v[30:0]});
			v = (ph == 4) ? 32'h7FFFFFFF : (ph == 5) ? 32'd1 : $urandom_range(1, 2000);
			write_reg(bou_pkg::CFG_DIST_PER_TICK, {$urandom_range(0, 1) != 0, v[30:0]});
			case (ph)
				1: v = 0;
				2: v = 15000;
				6: v = 16383;
				default: v = $urandom_range(0, 15000);
			endcase
			write_reg(bou_pkg::CFG_MAX_STEER, {$urandom_range(0, 1) != 0, 17'h0, v[13:0]});
			write_reg(CFG_SPARE_6, $urandom);
			write_reg(CFG_SPARE_7, $urandom);
			@(negedge clk);
			cfg_valid <= 1'b0;
			if (ph == 2) hold_reqs++;
			for (int k = 0; k < 170; k++) push_random();
			wait_drained();
		end

		repeat (700) @(posedge clk);
		if (expected_poses.size() > 0)
			report("missing beats", 64'(expected_poses.size()), 64'd0);
		if (errors == 0)
			$display("bicycle_odometry_update test passed");
		else
			$display("bicycle_odometry_update test failed");
		$finish;
	end
endmodule
